/* src/column_median_filter_decimating_defines.svh */
// Assertion helpers used by the checker file.
`ifndef COLUMN_MEDIAN_FILTER_DECIMATING_DEFINES_SVH
`define COLUMN_MEDIAN_FILTER_DECIMATING_DEFINES_SVH

// Checked only while out of reset.
`define CMFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CMFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cmfd_pkg.sv */
package cmfd_pkg;

  localparam int CMFD_MAX_WINDOW = 127;
  localparam int CMFD_MAX_ROWS   = 1024;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 7;
  localparam int OROW_W   = 10;
  localparam int BIT_W    = 4;

  localparam logic [SAMPLE_W-1:0] PAD_VALUE = 16'hFFFF;

  // register byte addresses
  localparam logic [2:0] ADDR_WINDOW_SIZE = 3'd0;
  localparam logic [2:0] ADDR_ROW_STEP    = 3'd4;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd9;
  localparam logic [CFG_W-1:0] ROW_STEP_RST    = 7'd1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_ISSUE  = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_DECIDE = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic accept;     // take the input sample
    logic clear;      // close the column
    logic div_init;   // load divider with the owed row
    logic div_step;
    logic sel_init;   // start the bitwise rank search
    logic issue;      // read one window element
    logic decide;     // finish one bit of the search
    logic advance;    // result transferred, move to next owed row
  } dp_cmd_t;

  typedef struct packed {
    logic due;
    logic col_end;
    logic div_last;
    logic elem_last;
    logic bit_last;
  } dp_stat_t;

endpackage

/* src/cmfd_ram.sv */
module cmfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/cmfd_ctrl.sv */
module cmfd_ctrl
  import cmfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.due) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.clear = stat.col_end;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          cmd.sel_init = 1'b1;
          state_nxt    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.elem_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.bit_last ? ST_OUT : ST_ISSUE;
      end
      ST_OUT: begin
        if (!out_stall) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

/* src/cmfd_dp.sv */
module cmfd_dp
  import cmfd_pkg::*;
#(
  parameter int MAX_WINDOW = CMFD_MAX_WINDOW,
  parameter int MAX_ROWS   = CMFD_MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [CFG_W-1:0]    window_size,
  input  logic [CFG_W-1:0]    row_step,
  input  logic [SAMPLE_W-1:0] depth_sample,
  input  logic                column_end,
  output logic [SAMPLE_W-1:0] median_value,
  output logic [OROW_W-1:0]   output_row,
  output logic                column_done
);

  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int EW    = RW + 8;
  localparam int DEPTH = 1 << $clog2(MAX_WINDOW);
  localparam int AW    = $clog2(DEPTH);

  localparam logic [RW-1:0]    MAX_ROWS_R = RW'(MAX_ROWS);
  localparam logic [RW-1:0]    LAST_ROW_R = RW'(MAX_ROWS - 1);
  localparam logic [CFG_W-1:0] MAXW_C     = CFG_W'(MAX_WINDOW);

  logic [RW-1:0] row_cnt_r, last_r, next_r;
  logic          end_r;

  logic [CFG_W-1:0] w_eff, s_eff, half, lead;

  always_comb begin
    w_eff = window_size;
    if (w_eff == '0) w_eff = CFG_W'(1);
    if (w_eff > MAXW_C) w_eff = MAXW_C;
    s_eff = (row_step == '0) ? CFG_W'(1) : row_step;
    half  = w_eff >> 1;
    lead  = end_r ? '0 : (w_eff - CFG_W'(1) - half);
  end

  logic [EW-1:0] next_adv;
  logic [RW-1:0] next_sat;
  logic          due;

  assign due      = (EW'(next_r) + EW'(lead)) <= EW'(last_r);
  assign next_adv = EW'(next_r) + EW'(s_eff);
  assign next_sat = (next_adv > EW'(MAX_ROWS_R)) ? MAX_ROWS_R : next_adv[RW-1:0];

  // sample intake
  logic we;
  assign we = cmd.accept && (row_cnt_r < MAX_ROWS_R);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      next_r    <= '0;
      last_r    <= '0;
      end_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        end_r <= column_end;
        if (we) begin
          last_r    <= row_cnt_r;
          row_cnt_r <= row_cnt_r + RW'(1);
        end else begin
          last_r <= LAST_ROW_R;
        end
      end
      if (cmd.advance) begin
        next_r <= next_sat;
      end
      if (cmd.clear) begin
        row_cnt_r <= '0;
        next_r    <= '0;
      end
    end
  end

  // restoring divider: output row = next_r / s_eff
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [RW-1:0]    dq_r;
  logic [BIT_W+1:0] dc_r;
  logic [CFG_W:0]   rem_sh;
  logic             ge;

  assign rem_sh  = {rem_r, dq_r[RW-1]};
  assign ge      = rem_sh >= {1'b0, s_eff};
  assign rem_nxt = ge ? CFG_W'(rem_sh - {1'b0, s_eff}) : rem_sh[CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      dq_r  <= next_r;
      dc_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[RW-2:0], ge};
      dc_r  <= dc_r + (BIT_W+2)'(1);
    end
  end

  // bitwise rank search: keep the largest t with count(v < t) <= half
  logic [SAMPLE_W-1:0] ans_r, t;
  logic [BIT_W-1:0]    b_r;
  logic [CFG_W-1:0]    e_r, cnt_r;
  logic                cmp_d_r, pad_d_r;
  logic [SAMPLE_W-1:0] rdata, val;

  logic signed [EW-1:0] row, row_back;
  logic                 row_ok;

  assign t        = ans_r | (SAMPLE_W'(1) << b_r);
  assign row      = $signed(EW'(next_r)) - $signed(EW'(half)) + $signed(EW'(e_r));
  assign row_back = $signed(EW'(last_r)) - row;
  assign row_ok   = (row >= 0) && (row_back >= 0) &&
                    (row_back < $signed(EW'(MAX_WINDOW)));
  assign val      = pad_d_r ? PAD_VALUE : rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_d_r <= 1'b0;
    end else begin
      cmp_d_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    pad_d_r <= !row_ok;
    if (cmd.sel_init) begin
      ans_r <= '0;
      b_r   <= BIT_W'(SAMPLE_W - 1);
      e_r   <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.issue) begin
        e_r <= e_r + CFG_W'(1);
      end
      if (cmp_d_r && (val < t)) begin
        cnt_r <= cnt_r + CFG_W'(1);
      end
      if (cmd.decide) begin
        if (cnt_r <= half) begin
          ans_r <= t;
        end
        cnt_r <= '0;
        e_r   <= '0;
        b_r   <= b_r - BIT_W'(1);
      end
    end
  end

  cmfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (we),
    .waddr (row_cnt_r[AW-1:0]),
    .wdata (depth_sample),
    .raddr (row[AW-1:0]),
    .rdata (rdata)
  );

  assign stat.due       = due;
  assign stat.col_end   = end_r;
  assign stat.div_last  = (dc_r == (BIT_W+2)'(RW - 1));
  assign stat.elem_last = (e_r == w_eff - CFG_W'(1));
  assign stat.bit_last  = (b_r == '0);

  assign median_value = ans_r;
  assign output_row   = OROW_W'(dq_r);
  assign column_done  = end_r && (next_sat > last_r);

endmodule

/* src/column_median_filter_decimating.sv */
// Sequence: a sample is taken in the idle state, then per owed result: a check,
//   RW = clog2(MAX_ROWS+1) divider steps, 16 rank-search passes over the window
//   RAM and a transfer to the output.
// A new sample is held off until the last one has been checked and its results
//   computed and transferred (one element read per cycle).
// Reset: synchronous active low; registers go to W=9, S=1, empty column.
//   No clearing pass: unread window entries are masked by row bounds.
module column_median_filter_decimating
  import cmfd_pkg::*;
#(
  parameter int MAX_WINDOW = CMFD_MAX_WINDOW,
  parameter int MAX_ROWS   = CMFD_MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_depth_sample,
  input  logic                in_column_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_median_value,
  output logic [OROW_W-1:0]   out_output_row,
  output logic                out_column_done,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [CFG_W-1:0] window_size_r, row_step_r;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RST;
      row_step_r    <= ROW_STEP_RST;
    end else if (wr) begin
      if (cfg_paddr == ADDR_WINDOW_SIZE) window_size_r <= cfg_pwdata[CFG_W-1:0];
      if (cfg_paddr == ADDR_ROW_STEP)    row_step_r    <= cfg_pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_WINDOW_SIZE: cfg_prdata = 32'(window_size_r);
      ADDR_ROW_STEP:    cfg_prdata = 32'(row_step_r);
      default:          cfg_prdata = '0;
    endcase
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cmfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cmfd_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .window_size  (window_size_r),
    .row_step     (row_step_r),
    .depth_sample (in_depth_sample),
    .column_end   (in_column_end),
    .median_value (out_median_value),
    .output_row   (out_output_row),
    .column_done  (out_column_done)
  );

endmodule

/* src/cmfd_checker.sv */
`include "column_median_filter_decimating_defines.svh"

module cmfd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a transfer in makes the input side busy in the next cycle
  `CMFD_ASSERT(a_busy_after_in, (in_valid && !in_stall) |=> in_stall, "input not held off")
  // no new sample while a result waits
  `CMFD_ASSERT(a_out_blocks_in, out_valid |-> in_stall, "input open while result pending")
  // a stalled result stays offered
  `CMFD_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "result dropped")
  // reset leaves no result pending
  `CMFD_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result after reset")

endmodule

bind column_median_filter_decimating cmfd_checker u_cmfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

/* bench/tb.sv */
module tb;
  import cmfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 2200;

  typedef struct {
    logic [SAMPLE_W-1:0] median;
    logic [OROW_W-1:0]   row;
    logic                done;
  } median_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_depth_sample;
  logic                in_column_end;
  logic                out_valid;
  logic                out_stall;
  logic [SAMPLE_W-1:0] out_median_value;
  logic [OROW_W-1:0]   out_output_row;
  logic                out_column_done;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [2:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  column_median_filter_decimating uut (.*);

  // mirror of the filter state
  logic [SAMPLE_W-1:0] col_window [CMFD_MAX_WINDOW];
  int unsigned         rows_seen;
  int unsigned         owed_row;
  int unsigned         win_reg;
  int unsigned         step_reg;

  median_result_t      pending_medians[$];
  int                  mismatch_count;
  int                  samples_sent;
  int                  medians_checked;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_cycles;
  int                  quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_column_model();
    for (int k = 0; k < CMFD_MAX_WINDOW; k++) col_window[k] = PAD_VALUE;
    rows_seen = 0;
    owed_row  = 0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] window_rank(int centre, int last, int w);
    logic [SAMPLE_W-1:0] vals [CMFD_MAX_WINDOW];
    logic [SAMPLE_W-1:0] v;
    int first;
    int row;
    int m;
    first = centre - w / 2;
    for (int k = 0; k < w; k++) begin
      row = first + k;
      v = PAD_VALUE;
      if (row >= 0 && row <= last && last - row < CMFD_MAX_WINDOW) v = col_window[last - row];
      m = k;
      while (m > 0 && vals[m-1] > v) begin
        vals[m] = vals[m-1];
        m--;
      end
      vals[m] = v;
    end
    return vals[w / 2];
  endfunction

  function automatic void predict_medians(logic [SAMPLE_W-1:0] sample, logic col_end);
    median_result_t r;
    int w;
    int s;
    int lead;
    int last;
    int count;
    w = (win_reg == 0) ? 1 : (win_reg > CMFD_MAX_WINDOW ? CMFD_MAX_WINDOW : win_reg);
    s = (step_reg == 0) ? 1 : step_reg;
    lead = w - 1 - w / 2;
    count = 0;
    if (rows_seen < CMFD_MAX_ROWS) begin
      for (int k = CMFD_MAX_WINDOW - 1; k > 0; k--) col_window[k] = col_window[k-1];
      col_window[0] = sample;
      last = rows_seen;
      rows_seen++;
    end else begin
      last = CMFD_MAX_ROWS - 1;
    end
    if (col_end) lead = 0;
    while (count < 64 && int'(owed_row) + lead <= last) begin
      r.median = window_rank(owed_row, last, w);
      r.row    = OROW_W'(owed_row / s);
      r.done   = 1'b0;
      pending_medians.push_back(r);
      count++;
      owed_row += s;
      if (owed_row > CMFD_MAX_ROWS) owed_row = CMFD_MAX_ROWS;
    end
    if (col_end) begin
      if (count > 0) pending_medians[pending_medians.size()-1].done = 1'b1;
      clear_column_model();
    end
  endfunction

  // result checking and watchdog
  always @(posedge clk) begin
    median_result_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_medians.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected median %0d row %0d done %0d", out_median_value,
                     out_output_row, out_column_done);
        end else begin
          exp_r = pending_medians.pop_front();
          medians_checked++;
          if (exp_r.median !== out_median_value || exp_r.row !== out_output_row ||
              exp_r.done !== out_column_done) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp median %0d row %0d done %0d, got %0d %0d %0d",
                       exp_r.median, exp_r.row, exp_r.done, out_median_value,
                       out_output_row, out_column_done);
          end
        end
      end
    end
  end

  // receiver: random stall, or a forced hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // call at a falling edge; returns at a falling edge
  task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic col_end);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_depth_sample = sample;
    in_column_end   = col_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_medians(sample, col_end);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (addr == ADDR_WINDOW_SIZE) win_reg = data & 32'h7F;
    else if (addr == ADDR_ROW_STEP) step_reg = data & 32'h7F;
  endtask

  task automatic set_filter(int w, int s);
    wait_idle();
    write_reg(ADDR_WINDOW_SIZE, w);
    write_reg(ADDR_ROW_STEP, s);
  endtask

  task automatic send_column(int len);
    logic [SAMPLE_W-1:0] v;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 5))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        2: v = SAMPLE_W'($urandom_range(0, 7));
        default: v = SAMPLE_W'($urandom);
      endcase
      send_sample(v, k == len - 1);
    end
  endtask

  task automatic test_defaults();
    // reset setting: W=9, S=1
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h0001, 1'b1);
  endtask

  task automatic test_register_edges();
    set_filter(0, 0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b1);
    set_filter(127, 127);
    send_sample(16'h0003, 1'b0);
    send_sample(16'h0002, 1'b1);
    set_filter(127, 1);
    send_sample(16'h0010, 1'b0);
    send_sample(16'h0000, 1'b1);
    // end mark with nothing owed: row 0 already given, next owed row past the end
    set_filter(1, 4);
    send_sample(16'h0042, 1'b0);
    send_sample(16'h0043, 1'b1);
    set_filter(2, 64);
    send_sample(16'hFFFE, 1'b1);
  endtask

  task automatic test_change_mid_column();
    set_filter(3, 1);
    for (int k = 0; k < 5; k++) send_sample(SAMPLE_W'($urandom), 1'b0);
    set_filter(5, 2);
    send_sample(SAMPLE_W'($urandom), 1'b0);
    send_sample(SAMPLE_W'($urandom), 1'b1);
  endtask

  task automatic test_backpressure();
    set_filter(3, 1);
    hold_cycles = 400;
    for (int k = 0; k < 20; k++) send_sample(SAMPLE_W'($urandom), k == 19);
  endtask

  task automatic test_random_columns(int n_items);
    int start;
    int w;
    int s;
    start = samples_sent;
    while (samples_sent - start < n_items) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 31) : $urandom_range(1, 9);
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 4);
      set_filter(w, s);
      repeat ($urandom_range(1, 3)) send_column($urandom_range(1, 24));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_depth_sample = '0;
    in_column_end = 1'b0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatch_count = 0;
    samples_sent = 0;
    medians_checked = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    win_reg = 32'(WINDOW_SIZE_RST);
    step_reg = 32'(ROW_STEP_RST);
    clear_column_model();
    send_idle_pct = 36;
    recv_idle_pct = 45;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_defaults();
    test_register_edges();
    test_change_mid_column();
    test_random_columns(40);
    send_idle_pct = 45;
    recv_idle_pct = 36;
    test_random_columns(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_columns(40);

    wait_idle();
    $display("covered %0d samples and %0d medians: window 0..127, step 0..127,",
             samples_sent, medians_checked);
    $display("mid-column register change, empty flush, long hold-off");
    if (mismatch_count == 0 && pending_medians.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d medians missing", mismatch_count, pending_medians.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
